FILE: sv/swg_pkg.sv
// Shared types and constants for the quantized SwiGLU gate.
// Used by swg_exp_cell, swg_div_cell and quantized_swiglu_gate. No dependencies.
package swg_pkg;

  localparam int SIG_F  = 16;            // sigmoid fraction bits
  localparam int Q_W    = SIG_F + 1;     // sigmoid / quotient width
  localparam int NUM_W  = SIG_F + 25;    // divider numerator width
  localparam int SLU_W  = SIG_F + 40;    // SiLU product width
  localparam int MAG_W  = 39;            // |code - 128| * scale
  localparam int EXP_W  = 25;            // Q.24 polynomial value
  localparam int EXP_N  = 6;             // Horner steps

  localparam logic [Q_W-1:0]   SIG_ONE  = Q_W'(1) << SIG_F;
  localparam logic [29:0]      CLAMP_Q24 = 30'h2000_0000;   // 32.0
  localparam logic [24:0]      LOG2E_Q24 = 25'd24204406;
  localparam logic [EXP_W-1:0] EXP_C5    = 25'd2584;

  // Horner coefficients in order of use, last one is 1.0
  localparam logic [EXP_W-1:0] EXP_COEF [EXP_N] = '{
    25'd22370, 25'd161365, 25'd931204, 25'd4030332, 25'd11629080, 25'd16777216
  };

  typedef enum logic [1:0] {
    CFG_GATE_SCALE = 2'd0,
    CFG_UP_SCALE   = 2'd1,
    CFG_OUT_RECIP  = 2'd2
  } cfg_idx_e;

  // token carried through the cell chains
  typedef struct packed {
    logic [MAG_W-1:0] gmag;
    logic [MAG_W-1:0] umag;
    logic             gneg;
    logic             uneg;
    logic [5:0]       n;
    logic [23:0]      f;
    logic [EXP_W-1:0] p;
    logic [25:0]      d;
    logic [25:0]      r;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
  } tok_t;

endpackage

FILE: sv/swg_exp_cell.sv
// One Horner step of the 2^-f polynomial, with its own beat register.
// Depends on swg_pkg.
module swg_exp_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  swg_pkg::tok_t             tok_i,
  input  logic [swg_pkg::EXP_W-1:0] coef_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output swg_pkg::tok_t             tok_o
);
  logic          valid_q;
  swg_pkg::tok_t tok_q, tok_d;
  logic [48:0]   prod;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    prod    = 49'(tok_i.p) * 49'(tok_i.f);
    tok_d   = tok_i;
    tok_d.p = coef_i - prod[48:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tok_q <= tok_d;
    end
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;
endmodule

FILE: sv/swg_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on swg_pkg.
module swg_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  swg_pkg::tok_t tok_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output swg_pkg::tok_t tok_o
);
  logic          valid_q;
  swg_pkg::tok_t tok_q, tok_d;
  logic [25:0]   rs;
  logic          ge;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    rs        = {tok_i.r[24:0], tok_i.nlo[swg_pkg::SIG_F]};
    ge        = (rs >= tok_i.d);
    tok_d     = tok_i;
    tok_d.r   = ge ? (rs - tok_i.d) : rs;
    tok_d.q   = {tok_i.q[swg_pkg::SIG_F-1:0], ge};
    tok_d.nlo = {tok_i.nlo[swg_pkg::SIG_F-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tok_q <= tok_d;
    end
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;
endmodule

FILE: sv/quantized_swiglu_gate.sv
// Quantized SwiGLU gate top level: dequant, sigmoid, SiLU, product, requant.
// Depends on swg_pkg, swg_exp_cell, swg_div_cell.
//
//  channel   dir  beat content
//  s_axis    in   tdata[7:0] gate_code, tdata[15:8] up_code
//  m_axis    out  tdata[7:0] out_code
//  cfg       in   cfg_we_i, cfg_idx_i (0 gate, 1 up, 2 recip), cfg_data_i
//
// One beat per cycle sustained while m_axis accepts. Stages in order: two front stages,
// six Horner cells, one divisor stage, 17 divider cells, five back stages.
// Every stage holds its own valid bit; ready ripples back from m_axis, so
// empty stages fill while a finished result waits at the output.
// Reset clears all valid bits and loads the scales with 1.0.
module quantized_swiglu_gate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // gate_code[7:0], up_code[15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_code[7:0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int DIV_N = swg_pkg::Q_W;
  localparam int EXP_N = swg_pkg::EXP_N;

  // config registers
  logic [31:0] gate_scale_q, up_scale_q, recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_scale_q <= 32'h0100_0000;
      up_scale_q   <= 32'h0100_0000;
      recip_q      <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swg_pkg::CFG_GATE_SCALE: gate_scale_q <= cfg_data_i;
        swg_pkg::CFG_UP_SCALE:   up_scale_q   <= cfg_data_i;
        swg_pkg::CFG_OUT_RECIP:  recip_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

  logic                exp_v [EXP_N+1];
  logic                exp_r [EXP_N+1];
  swg_pkg::tok_t       exp_t [EXP_N+1];
  logic                div_v [DIV_N+1];
  logic                div_r [DIV_N+1];
  swg_pkg::tok_t       div_t [DIV_N+1];

  assign rdy8 = !v8_q || m_axis_tready;
  assign rdy7 = !v7_q || rdy8;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || div_r[0];
  assign rdy2 = !v2_q || exp_r[0];
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= exp_v[EXP_N];
      if (rdy4) v4_q <= div_v[DIV_N];
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  // stage 1: dequantize magnitudes
  logic [7:0]    gc, uc, gm, um;
  logic [39:0]   gprod, uprod;
  swg_pkg::tok_t t1_d, t1_q;

  always_comb begin
    gc    = s_axis_tdata[7:0];
    uc    = s_axis_tdata[15:8];
    gm    = gc[7] ? {1'b0, gc[6:0]} : 8'(8'd128 - gc);
    um    = uc[7] ? {1'b0, uc[6:0]} : 8'(8'd128 - uc);
    gprod = 40'(gm) * 40'(gate_scale_q);
    uprod = 40'(um) * 40'(up_scale_q);
    t1_d      = '0;
    t1_d.gmag = gprod[swg_pkg::MAG_W-1:0];
    t1_d.umag = uprod[swg_pkg::MAG_W-1:0];
    t1_d.gneg = !gc[7];
    t1_d.uneg = !uc[7];
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy1) t1_q <= t1_d;
  end

  // stage 2: clamp and scale by log2(e), split integer and fraction
  logic [29:0]   clamp_a;
  logic [54:0]   lg_prod;
  swg_pkg::tok_t t2_d, t2_q;

  always_comb begin
    clamp_a = (t1_q.gmag >= swg_pkg::MAG_W'(swg_pkg::CLAMP_Q24)) ? swg_pkg::CLAMP_Q24
                                                               : t1_q.gmag[29:0];
    lg_prod = 55'(clamp_a) * 55'(swg_pkg::LOG2E_Q24);
    t2_d    = t1_q;
    t2_d.n  = lg_prod[53:48];
    t2_d.f  = lg_prod[47:24];
    t2_d.p  = swg_pkg::EXP_C5;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) t2_q <= t2_d;
  end

  // Horner chain for 2^-f
  assign exp_v[0]     = v2_q;
  assign exp_t[0]     = t2_q;
  assign exp_r[EXP_N] = rdy3;

  for (genvar k = 0; k < EXP_N; k++) begin : g_exp
    swg_exp_cell u_exp (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (exp_v[k]),
      .in_ready_o  (exp_r[k]),
      .tok_i       (exp_t[k]),
      .coef_i      (swg_pkg::EXP_COEF[k]),
      .out_valid_o (exp_v[k+1]),
      .out_ready_i (exp_r[k+1]),
      .tok_o       (exp_t[k+1])
    );
  end

  // stage 3: divisor d = 1 + e, numerator 2^(F+24) + d/2, first remainder
  logic [swg_pkg::EXP_W-1:0] e_val;
  logic [25:0]               d_val;
  logic [swg_pkg::NUM_W-1:0] num;
  swg_pkg::tok_t             t3_d, t3_q;

  always_comb begin
    e_val    = exp_t[EXP_N].p >> exp_t[EXP_N].n;
    d_val    = 26'h100_0000 + 26'(e_val);
    num      = (swg_pkg::NUM_W'(1) << (swg_pkg::NUM_W - 1)) + swg_pkg::NUM_W'(d_val[25:1]);
    t3_d     = exp_t[EXP_N];
    t3_d.d   = d_val;
    t3_d.r   = 26'(num[swg_pkg::NUM_W-1:swg_pkg::Q_W]);
    t3_d.nlo = num[swg_pkg::SIG_F:0];
    t3_d.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (exp_v[EXP_N] && rdy3) t3_q <= t3_d;
  end

  // divider chain, one quotient bit per cell
  assign div_v[0]     = v3_q;
  assign div_t[0]     = t3_q;
  assign div_r[DIV_N] = rdy4;

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    swg_div_cell u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_v[k]),
      .in_ready_o  (div_r[k]),
      .tok_i       (div_t[k]),
      .out_valid_o (div_v[k+1]),
      .out_ready_i (div_r[k+1]),
      .tok_o       (div_t[k+1])
    );
  end

  // stage 4: sigmoid and SiLU magnitude
  logic [swg_pkg::Q_W-1:0]   sig;
  logic [swg_pkg::SLU_W-1:0] slu_sum;
  logic [39:0]               silu_q;
  logic [swg_pkg::MAG_W-1:0] umag4_q;
  logic                      neg4_q, neg5_q, neg6_q, neg7_q;

  always_comb begin
    sig     = div_t[DIV_N].gneg ? (swg_pkg::SIG_ONE - div_t[DIV_N].q) : div_t[DIV_N].q;
    slu_sum = swg_pkg::SLU_W'(div_t[DIV_N].gmag) * swg_pkg::SLU_W'(sig)
            + (swg_pkg::SLU_W'(1) << (swg_pkg::SIG_F - 1));
  end

  always_ff @(posedge clk_i) begin
    if (div_v[DIV_N] && rdy4) begin
      silu_q  <= slu_sum[swg_pkg::SIG_F+39:swg_pkg::SIG_F];
      umag4_q <= div_t[DIV_N].umag;
      neg4_q  <= div_t[DIV_N].gneg ^ div_t[DIV_N].uneg;
    end
  end

  // stage 5: silu * umag as four partials, two 20x20 and two 20x19
  logic [39:0] pp_ll_q, pp_hl_q;
  logic [38:0] pp_lh_q, pp_hh_q;

  always_ff @(posedge clk_i) begin
    if (v4_q && rdy5) begin
      pp_ll_q <= 40'(silu_q[19:0])  * 40'(umag4_q[19:0]);
      pp_lh_q <= 39'(silu_q[19:0])  * 39'(umag4_q[38:20]);
      pp_hl_q <= 40'(silu_q[39:20]) * 40'(umag4_q[19:0]);
      pp_hh_q <= 39'(silu_q[39:20]) * 39'(umag4_q[38:20]);
      neg5_q  <= neg4_q;
    end
  end

  // stage 6: sum partials
  logic [79:0] prod_sum;
  logic [78:0] prod_q;

  assign prod_sum = 80'(pp_ll_q) + (80'(41'(pp_lh_q) + 41'(pp_hl_q)) << 20)
                  + (80'(pp_hh_q) << 40);

  always_ff @(posedge clk_i) begin
    if (v5_q && rdy6) begin
      prod_q <= prod_sum[78:0];
      neg6_q <= neg5_q;
    end
  end

  // stage 7: times reciprocal scale, three partials: two 27x32 and one 25x32
  logic [58:0] rp0_q, rp1_q;
  logic [56:0] rp2_q;

  always_ff @(posedge clk_i) begin
    if (v6_q && rdy7) begin
      rp0_q  <= 59'(prod_q[26:0])  * 59'(recip_q);
      rp1_q  <= 59'(prod_q[53:27]) * 59'(recip_q);
      rp2_q  <= 57'(prod_q[78:54]) * 57'(recip_q);
      neg7_q <= neg6_q;
    end
  end

  // stage 8: round half up at bit 64, saturate, re-offset
  logic [111:0] fin_sum;
  logic [47:0]  mag;
  logic         big;
  logic [7:0]   out_d, out_q;

  always_comb begin
    fin_sum = 112'(rp0_q) + (112'(rp1_q) << 27) + (112'(rp2_q) << 54)
            + (112'(1) << 63);
    mag     = fin_sum[111:64];
    big     = |mag[47:7];
    if (neg7_q) begin
      out_d = big ? 8'd0 : 8'(8'd128 - mag[7:0]);
    end else begin
      out_d = (big || (mag[6:0] == 7'h7F)) ? 8'd255 : {1'b1, mag[6:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v7_q && rdy8) out_q <= out_d;
  end

  assign m_axis_tvalid = v8_q;
  assign m_axis_tdata  = out_q;
endmodule

FILE: sv/swg_checker.sv
// Port-level checks for quantized_swiglu_gate, bound to the top level.
// Depends on quantized_swiglu_gate.
module swg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  // held output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // a free output side never stalls the input side
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

bind quantized_swiglu_gate swg_checker u_swg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/quantized_swiglu_gate_tb.sv
// Self-checking testbench for quantized_swiglu_gate: directed and random beats.
// Depends on swg_pkg and the quantized_swiglu_gate RTL.
module quantized_swiglu_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SF = 16;          // sigmoid fraction bits
  localparam int LATENCY = 31;
  localparam int LIMIT = 1000000;

  // Golden model of the gate datapath plus a queue of expected output codes.
  class swiglu_scoreboard;
    logic [31:0] gate_scale, up_scale, recip;
    logic [7:0] out_q[$];
    int errors;

    function new();
      gate_scale = 32'h0100_0000;
      up_scale = 32'h0100_0000;
      recip = 32'h0001_0000;
      errors = 0;
    endfunction

    // 2^-f for f in [0,1), Q.24
    function logic [63:0] exp2_frac(logic [63:0] f);
      logic [63:0] c[6];
      logic [63:0] p;
      c = '{64'd11629080, 64'd4030332, 64'd931204, 64'd161365, 64'd22370, 64'd2584};
      p = c[5];
      for (int k = 4; k >= 0; k--) p = c[k] - ((p * f) >> 24);
      return 64'd16777216 - ((p * f) >> 24);
    endfunction

    function logic [63:0] sigmoid_q(logic [63:0] mag, bit neg);
      logic [63:0] a, t, n, f, e, d, sp;
      a = (mag < (64'd32 << 24)) ? mag : (64'd32 << 24);
      t = (a * 64'd24204406) >> 24;
      n = t >> 24;
      f = t & 64'hFF_FFFF;
      e = exp2_frac(f) >> n;
      d = 64'd16777216 + e;
      sp = ((64'd1 << (SF + 24)) + (d >> 1)) / d;
      return neg ? (64'd1 << SF) - sp : sp;
    endfunction

    function void note_input(logic [7:0] gc, logic [7:0] uc);
      logic [63:0] gm, um, s, silu;
      logic [191:0] prod;
      logic [63:0] mag;
      bit gn, un;
      int v;
      gn = gc < 128;
      un = uc < 128;
      gm = 64'(gn ? 128 - gc : gc - 128) * 64'(gate_scale);
      um = 64'(un ? 128 - uc : uc - 128) * 64'(up_scale);
      s = sigmoid_q(gm, gn);
      silu = (gm * s + (64'd1 << (SF - 1))) >> SF;
      prod = 192'(silu) * 192'(um) * 192'(recip) + (192'd1 << 63);
      mag = 64'(prod >> 64);
      if (gn != un) v = (mag >= 128) ? -128 : -int'(mag);
      else v = (mag >= 127) ? 127 : int'(mag);
      out_q = {out_q, 8'(v + 128)};
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] exp_code;
      if (out_q.size() == 0) begin
        $error("out_code: unexpected beat, actual %0d", got);
        errors++;
        return;
      end
      exp_code = out_q.pop_front();
      if (got !== exp_code) begin
        $error("out_code: expected %0d actual %0d", exp_code, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // gate_code[7:0], up_code[15:8]
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [7:0] m_axis_tdata;        // out_code[7:0]
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = swg_pkg::CFG_GATE_SCALE;
  logic [31:0] cfg_data_i = '0;

  swiglu_scoreboard sb = new();
  int cycles = 0;
  bit stall_mode = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  quantized_swiglu_gate DUT (.*);

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output monitor: score every accepted result beat.
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // Receiver backpressure: alternating bursty and free-running patterns.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Register write; caller guarantees the pipeline is drained.
  task automatic write_reg(swg_pkg::cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      swg_pkg::CFG_GATE_SCALE: sb.gate_scale = val;
      swg_pkg::CFG_UP_SCALE:   sb.up_scale = val;
      default:                 sb.recip = val;
    endcase
  endtask

  task automatic drain();
    while (sb.out_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Send one beat; returns at the falling edge after acceptance.
  task automatic send_beat(logic [7:0] gc, logic [7:0] uc, bit keep_valid);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {uc, gc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(gc, uc);
    @(negedge clk_i);
    if (!keep_valid) s_axis_tvalid <= 0;
  endtask

  // Random items in bursts with gaps; gate values biased toward extremes, up values toward the zero point.
  task automatic random_run(int count);
    int burst, gap;
    logic [7:0] g, u;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      for (int i = 0; i < burst && count > 0; i++) begin
        g = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
        u = ($urandom_range(0, 7) == 0) ? 8'(128 + $urandom_range(0, 2) - 1) : 8'($urandom);
        count--;
        send_beat(g, u, ((i < burst - 1) || (gap == 0)) && (count > 0));
      end
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] gs[4], us[4], rs[4];
    logic [7:0] dir_g[10], dir_u[10];
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, zero points, large gates of both signs.
    dir_g = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd129, 8'd0, 8'd255, 8'd200, 8'd60, 8'd1};
    dir_u = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd129, 8'd127, 8'd254};
    for (int i = 0; i < 10; i++) send_beat(dir_g[i], dir_u[i], i < 9);
    drain();
    // Zero scales and zero reciprocal give the zero code.
    write_reg(swg_pkg::CFG_GATE_SCALE, 32'h0);
    for (int i = 0; i < 3; i++) send_beat(dir_g[i], dir_u[i], i < 2);
    drain();
    write_reg(swg_pkg::CFG_GATE_SCALE, 32'h0100_0000);
    write_reg(swg_pkg::CFG_UP_SCALE, 32'h0);
    for (int i = 0; i < 3; i++) send_beat(dir_g[i], dir_u[i], i < 2);
    drain();
    write_reg(swg_pkg::CFG_UP_SCALE, 32'hFFFF_FFFF);
    write_reg(swg_pkg::CFG_OUT_RECIP, 32'h0);
    for (int i = 0; i < 3; i++) send_beat(dir_g[i], dir_u[i], i < 2);
    drain();

    // Random phases across several register settings.
    gs = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0004_0000, 32'h0};
    us = '{32'h0100_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0300_0000};
    rs = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_4000};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        write_reg(swg_pkg::CFG_GATE_SCALE, gs[ph]);
        write_reg(swg_pkg::CFG_UP_SCALE, us[ph]);
        write_reg(swg_pkg::CFG_OUT_RECIP, rs[ph]);
      end else begin
        write_reg(swg_pkg::CFG_GATE_SCALE,
                  (ph == 5) ? $urandom : $urandom_range(0, 32'h0400_0000));
        write_reg(swg_pkg::CFG_UP_SCALE,
                  (ph == 6) ? $urandom : $urandom_range(0, 32'h0400_0000));
        write_reg(swg_pkg::CFG_OUT_RECIP,
                  (ph == 7) ? $urandom : $urandom_range(0, 32'h0004_0000));
      end
      random_run(225);
      drain();
    end

    if (sb.errors == 0 && sb.out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.out_q.size() != 0) $error("out_code: %0d results never arrived", sb.out_q.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/swg_pkg.sv
sv/swg_exp_cell.sv
sv/swg_div_cell.sv
sv/quantized_swiglu_gate.sv
sv/swg_checker.sv
tb/sv/quantized_swiglu_gate_tb.sv
